FILE: design/binary_to_decimal_ascii_defines.svh
// Assertion macros for the checker file, bdc_checker.sv.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Antecedent and consequent hold in the same cycle.
`define BDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binary_to_decimal_ascii: implication check failed");

// Consequent holds in the cycle after the antecedent.
`define BDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binary_to_decimal_ascii: next-cycle check failed");

`endif

FILE: design/bdc_pkg.sv
`default_nettype none
package bdc_pkg;

  localparam int DEFAULT_INPUT_WIDTH = 32;
  localparam int DIGIT_W             = 4;
  localparam int CHAR_W              = 8;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  TERMINATOR    = 8'h00;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;

  // Decimal digits needed for a w-bit unsigned number: floor(w * log10(2)) + 1.
  function automatic int num_digits(input int w);
    return (w * 30103) / 100000 + 1;
  endfunction

  // Per-cycle command to every digit cell.
  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/bdc_stream_if.sv
`default_nettype none
interface bdc_in_if import bdc_pkg::*; #(
  parameter int WIDTH = DEFAULT_INPUT_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdc_out_if import bdc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface
`default_nettype wire

FILE: design/binary_to_decimal_ascii.sv
`default_nettype none
// Converts one unsigned INPUT_WIDTH-bit number per input transaction into its
// decimal ASCII text, most significant digit first, without leading zeros
// (zero gives a single '0'), followed by a 0x00 terminator byte flagged with
// last. Each number is shifted and adjusted bit by bit through the row of
// decimal digit cells, then its digits are walked out of the top cell, then
// the terminator is sent and the block returns to idle; the output side can
// stall the digits and the terminator. The block handles one number at a
// time; a new number is accepted while the terminator of the previous one
// still waits in the output register. Reset is synchronous.
module binary_to_decimal_ascii import bdc_pkg::*; #(
  parameter int INPUT_WIDTH = DEFAULT_INPUT_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst,
  bdc_in_if.sink    in_ch,
  bdc_out_if.source out_ch
);

  localparam int NUM_DIGITS = num_digits(INPUT_WIDTH);
  localparam int BIT_W      = $clog2(INPUT_WIDTH);
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_TERM = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [INPUT_WIDTH-1:0] shreg;
  logic [BIT_W-1:0]       bit_cnt;
  logic [CNT_W-1:0]       remaining, remaining_next;
  logic                   started, started_next;
  logic                   out_valid, out_valid_next;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;

  cell_ctrl_t             cell_ctrl;
  logic [DIGIT_W-1:0]     digit [NUM_DIGITS];
  logic                   carry [NUM_DIGITS];

  logic in_fire;
  logic slot_free;
  logic emit_now;
  logic load_digit;
  logic load_term;

  assign in_ch.ready     = (state == ST_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign slot_free       = !out_valid || out_ch.ready;

  // The top cell holds the most significant digit still pending. A leading
  // zero is dropped without output, except the units digit, which always shows.
  assign emit_now = started || (digit[NUM_DIGITS-1] != '0) ||
                    (remaining == CNT_W'(1));

  // The row of digit cells. Cell 0 is the units digit; during conversion it
  // takes the next binary bit, and each higher cell takes its lower neighbor's
  // carry. During output every digit moves up one place per step.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic               bit_in;
    logic [DIGIT_W-1:0] digit_in;

    if (i == 0) begin : g_first
      assign bit_in   = shreg[INPUT_WIDTH-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end

    bdc_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .bit_in    (bit_in),
      .digit_in  (digit_in),
      .carry_out (carry[i]),
      .digit     (digit[i])
    );
  end

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    started_next   = started;
    cell_ctrl      = '0;
    load_digit     = 1'b0;
    load_term      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cell_ctrl.clear = 1'b1;
          state_next      = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
        if (bit_cnt == '0) begin
          remaining_next = CNT_W'(NUM_DIGITS);
          started_next   = 1'b0;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // A digit that must be shown waits for a free output register;
        // a suppressed leading zero just moves out of the way.
        if (!emit_now || slot_free) begin
          cell_ctrl.move = 1'b1;
          remaining_next = remaining - CNT_W'(1);
          load_digit     = emit_now;
          started_next   = started || emit_now;
          if (remaining == CNT_W'(1)) begin
            state_next = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          load_term  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_digit || load_term) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    started   <= started_next;
    if (in_fire) begin
      shreg   <= in_ch.value[INPUT_WIDTH-1:0];
      bit_cnt <= BIT_W'(INPUT_WIDTH - 1);
    end else if (state == ST_CONV) begin
      shreg   <= {shreg[INPUT_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_W'(1);
    end
    if (load_digit) begin
      out_char <= ASCII_ZERO + CHAR_W'(digit[NUM_DIGITS-1]);
      out_last <= 1'b0;
    end else if (load_term) begin
      out_char <= TERMINATOR;
      out_last <= 1'b1;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.char_out = out_char;
  assign out_ch.last     = out_last;

endmodule
`default_nettype wire

FILE: design/bdc_cell.sv
`default_nettype none
module bdc_cell import bdc_pkg::*; (
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               bit_in,
  input  wire logic [DIGIT_W-1:0] digit_in,
  output logic                    carry_out,
  output logic [DIGIT_W-1:0]      digit
);

  logic [DIGIT_W-1:0] adj;

  // Add three before the shift so the doubled digit wraps into the next decade.
  assign adj       = (digit >= DABBLE_LIMIT) ? digit + DABBLE_ADJUST : digit;
  assign carry_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.move) begin
      digit <= digit_in;
    end
  end

endmodule
`default_nettype wire

FILE: design/bdc_checker.sv
`default_nettype none
`include "binary_to_decimal_ascii_defines.svh"
module bdc_checker import bdc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] char_out,
  input wire logic              last
);

  // Numbers accepted whose terminator has not yet been taken.
  logic [1:0] pending;
  logic       in_fire;
  logic       end_fire;

  assign in_fire  = in_valid && in_ready;
  assign end_fire = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_fire) - 2'(end_fire);
    end
  end

  `BDC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(char_out) && $stable(last))
  `BDC_ASSERT_IMP(a_term_zero, out_valid && last, char_out == TERMINATOR)
  `BDC_ASSERT_IMP(a_digit_range, out_valid && !last,
                  char_out >= ASCII_ZERO && char_out <= ASCII_ZERO + 8'd9)
  `BDC_ASSERT_IMP(a_no_orphan, out_valid, pending != 2'd0)

endmodule

bind binary_to_decimal_ascii bdc_checker u_bdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_out  (out_ch.char_out),
  .last      (out_ch.last)
);
`default_nettype wire

FILE: dv/binary_to_decimal_ascii_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the binary to decimal ASCII converter. Numbers go in
// through the input channel. Every character that comes out is compared with
// the decimal text that the bench works out by itself for each accepted number.
module binary_to_decimal_ascii_test;
  import bdc_pkg::*;

  localparam int WIDTH          = DEFAULT_INPUT_WIDTH;
  localparam int RANDOM_NUMBERS = 340;
  // Cycles with no transaction on either channel before the run is abandoned.
  // This is well above the longest stretch a correct run can have, which is the
  // receiver hold-off below plus one conversion.
  localparam int QUIET_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  // Wait after the last expected character, to catch any stray output.
  localparam int TAIL_CYCLES    = 60;

  // One character of decimal text, with the flag that marks the terminator.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } ascii_char_t;

  // A number that is waiting to be offered. When hold_for_drain is set, the
  // sender keeps it back until every character already predicted has arrived.
  typedef struct {
    logic [WIDTH-1:0] value;
    bit               hold_for_drain;
  } pending_number_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdc_in_if #(.WIDTH(WIDTH)) in_ch ();
  bdc_out_if                 out_ch ();

  binary_to_decimal_ascii #(.INPUT_WIDTH(WIDTH)) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Period of 10 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_number_t pending_numbers[$];
  ascii_char_t     expected_text[$];

  int  numbers_accepted = 0;
  int  chars_checked    = 0;
  int  error_count      = 0;
  int  quiet_cycles     = 0;
  int  holdoff_left     = 0;
  bit  holdoff_done     = 1'b0;
  // Set for one cycle after the rising edge at which the input transaction
  // completed, so the driver knows at the falling edge that it may move on.
  bit  number_taken     = 1'b0;

  // Appends the expected characters of one number: its decimal digits with
  // leading zeros dropped, most significant first, then the terminator. Zero
  // still gives one digit because the loop always runs once.
  task automatic push_decimal_text(input logic [WIDTH-1:0] number);
    logic [WIDTH-1:0]  remaining;
    logic [CHAR_W-1:0] digit_chars[20];
    int                count;
    remaining = number;
    count     = 0;
    do begin
      digit_chars[count] = ASCII_ZERO + CHAR_W'(remaining % 10);
      count++;
      remaining = remaining / 10;
    end while (remaining != 0);
    for (int i = count - 1; i >= 0; i--) begin
      expected_text.push_back('{char_code: digit_chars[i], last: 1'b0});
    end
    expected_text.push_back('{char_code: TERMINATOR, last: 1'b1});
  endtask

  // Input driver. A number stays on the channel until it is taken. Once it is
  // taken, or while the channel is empty, the sender may offer the next one or
  // stay idle. The idle rate follows the phase of the run: 32 percent
  // first, 47 percent next, none in the last stretch.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || number_taken) begin
      if (pending_numbers.size() != 0 &&
          $urandom_range(0, 99) >= ((numbers_accepted < 120) ? 32 :
                                    (numbers_accepted < 240) ? 47 : 0) &&
          (!pending_numbers[0].hold_for_drain || expected_text.size() == 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= pending_numbers[0].value;
        void'(pending_numbers.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output receiver. Its stall rate mirrors the sender: 47 percent first, then
  // 32 percent, then none. Once, early in the run, it refuses characters for a
  // long stretch while the sender keeps offering numbers, so the block backs
  // up and has to hold off its input.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_ch.ready <= 1'b0;
      holdoff_left--;
    end else if (!holdoff_done && numbers_accepted >= 60) begin
      out_ch.ready <= 1'b0;
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
    end else begin
      out_ch.ready <= $urandom_range(0, 99) >= ((numbers_accepted < 120) ? 47 :
                                                (numbers_accepted < 240) ? 32 : 0);
    end
  end

  // Monitor. On each rising edge it records an input transaction by predicting
  // that number's text, and checks an output transaction against the oldest
  // character still expected. It also runs the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      number_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      number_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        push_decimal_text(in_ch.value);
        numbers_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("char_out 0x%02h (last %0b) arrived with no character expected",
                 out_ch.char_out, out_ch.last);
          error_count++;
        end else begin
          if (out_ch.char_out !== expected_text[0].char_code) begin
            $error("char_out mismatch: expected 0x%02h, actual 0x%02h",
                   expected_text[0].char_code, out_ch.char_out);
            error_count++;
          end
          if (out_ch.last !== expected_text[0].last) begin
            $error("last mismatch: expected %0b, actual %0b",
                   expected_text[0].last, out_ch.last);
            error_count++;
          end
          void'(expected_text.pop_front());
          chars_checked++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no transaction for %0d cycles, %0d characters still expected",
               quiet_cycles, expected_text.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus and end of run. The directed numbers cover zero, the single and
  // two digit edges, the steps to three and to ten digits, the signed
  // midpoint and the full 32-bit maximum. Alternating bit patterns and the
  // extremes make every input bit take both values.
  initial begin
    logic [WIDTH-1:0] powers_of_ten[10];
    logic [WIDTH-1:0] number;
    int               sel;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    powers_of_ten[0] = 1;
    for (int k = 1; k < 10; k++) begin
      powers_of_ten[k] = powers_of_ten[k - 1] * 10;
    end

    pending_numbers.push_back('{32'd0, 1'b0});
    pending_numbers.push_back('{32'd1, 1'b0});
    pending_numbers.push_back('{32'd7, 1'b0});
    pending_numbers.push_back('{32'd9, 1'b0});
    pending_numbers.push_back('{32'd10, 1'b0});
    pending_numbers.push_back('{32'd11, 1'b0});
    pending_numbers.push_back('{32'd99, 1'b0});
    pending_numbers.push_back('{32'd100, 1'b0});
    pending_numbers.push_back('{32'd101, 1'b0});
    pending_numbers.push_back('{32'd12345, 1'b0});
    pending_numbers.push_back('{32'd4294967, 1'b0});
    pending_numbers.push_back('{32'd999999999, 1'b0});
    pending_numbers.push_back('{32'd1000000000, 1'b0});
    pending_numbers.push_back('{32'd1000000001, 1'b0});
    pending_numbers.push_back('{32'd2147483647, 1'b0});
    pending_numbers.push_back('{32'd2147483648, 1'b0});
    pending_numbers.push_back('{32'd4294967294, 1'b0});
    pending_numbers.push_back('{32'd4294967295, 1'b0});
    pending_numbers.push_back('{32'h5555_5555, 1'b0});
    pending_numbers.push_back('{32'hAAAA_AAAA, 1'b0});

    // Random numbers. Shifting a full random word right by a random amount
    // spreads them over every digit count. Some sit right at or just below a
    // power of ten, where the digit count changes, and some are tiny. Two of
    // them wait until the block has gone completely quiet.
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        number = powers_of_ten[$urandom_range(0, 9)] - $urandom_range(0, 1);
      end else if (sel == 1) begin
        number = $urandom_range(0, 99);
      end else begin
        number = $urandom >> $urandom_range(0, 31);
      end
      pending_numbers.push_back('{number, (n == 0 || n == 180)});
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_numbers.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_text.size() != 0) begin
      $error("%0d characters never arrived", expected_text.size());
      error_count++;
    end
    $display("Converted %0d numbers into %0d checked characters, from zero to the",
             numbers_accepted, chars_checked);
    $display("32-bit maximum, under random stalls, a long output hold-off and a drain.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
